>>> rtl/bole_pkg.sv
// Shared constants, opcodes and beat types for the bounded ordered list engine.
package bole_pkg;

    // List geometry
    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    // Port field widths
    localparam int OP_W  = 4;
    localparam int VAL_W = 32;
    localparam int POS_W = 7;
    localparam int NUM_W = 7;

    // Common width for position / count compares
    localparam int PCMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Opcodes
    localparam logic [OP_W-1:0] OP_INS_FRONT  = 4'd0;
    localparam logic [OP_W-1:0] OP_INS_REAR   = 4'd1;
    localparam logic [OP_W-1:0] OP_INS_SORTED = 4'd2;
    localparam logic [OP_W-1:0] OP_INS_AT     = 4'd3;
    localparam logic [OP_W-1:0] OP_SEARCH     = 4'd4;
    localparam logic [OP_W-1:0] OP_DEL_FRONT  = 4'd5;
    localparam logic [OP_W-1:0] OP_DEL_REAR   = 4'd6;
    localparam logic [OP_W-1:0] OP_DEL_AT     = 4'd7;
    localparam logic [OP_W-1:0] OP_DEL_ITEM   = 4'd8;
    localparam logic [OP_W-1:0] OP_DEL_ALL    = 4'd9;

    // One command as seen by the engine
    typedef struct packed {
        logic [OP_W-1:0]       op;
        logic [DATA_WIDTH-1:0] word;
        logic [POS_W-1:0]      pos;
    } t_cmd;

    // One result beat
    typedef struct packed {
        logic             ok;
        logic             found;
        logic [VAL_W-1:0] value;
        logic [NUM_W-1:0] removed;
        logic [NUM_W-1:0] count;
    } t_result;

endpackage

>>> rtl/bole_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module bole_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/bole_eng.sv
// List sequencer: scan, compaction and shift passes over the entry RAM.
module bole_eng (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  bole_pkg::t_cmd   i_cmd,
    input  logic             i_take,
    output logic             o_idle,
    output logic             o_done,
    output bole_pkg::t_result o_res
);
    import bole_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ASC  = 2'd1;
    localparam logic [1:0] ST_DESC = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]        r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_ra, n_ra;
    logic              r_dv, n_dv;
    logic [ADDR_W-1:0] r_di, n_di;
    logic [CNT_W-1:0]  r_j, n_j;
    logic              r_hit, n_hit;
    logic [CNT_W-1:0]  r_slot, n_slot;
    logic [PCMP_W-1:0] r_tgt, n_tgt;
    t_result           r_res, n_res;

    logic                  ram_we, ram_re;
    logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
    logic [DATA_WIDTH-1:0] ram_wdata, rd;

    logic             is_pos_del, key_match, pos_match, match, drop, full;
    logic [CNT_W-1:0] removed;
    logic [VAL_W-1:0] key_sext;

    bole_ram #(
        .WIDTH(DATA_WIDTH),
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(rd)
    );

    // Command decode and per-entry match
    assign is_pos_del = (r_cmd.op == OP_DEL_FRONT) || (r_cmd.op == OP_DEL_REAR)
                     || (r_cmd.op == OP_DEL_AT);
    assign key_match  = (rd == r_cmd.word);
    assign pos_match  = (PCMP_W'(r_di) == r_tgt);
    assign match      = is_pos_del ? pos_match : key_match;
    assign drop       = match && ((r_cmd.op == OP_DEL_ALL) || !r_hit);
    assign full       = (r_cnt == CNT_W'(CAPACITY));
    assign removed    = r_cnt - r_j;
    assign key_sext   = VAL_W'($signed(r_cmd.word));

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_cnt     = r_cnt;
        n_ra      = r_ra;
        n_dv      = r_dv;
        n_di      = r_di;
        n_j       = r_j;
        n_hit     = r_hit;
        n_slot    = r_slot;
        n_tgt     = r_tgt;
        n_res     = r_res;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_cmd         = i_cmd;
                    n_ra          = '0;
                    n_dv          = 1'b0;
                    n_j           = '0;
                    n_hit         = 1'b0;
                    n_res.ok      = 1'b0;
                    n_res.found   = 1'b0;
                    n_res.value   = '1;
                    n_res.removed = '0;
                    n_res.count   = NUM_W'(r_cnt);
                    unique case (i_cmd.op)
                        OP_INS_FRONT, OP_INS_REAR: begin
                            n_slot  = (i_cmd.op == OP_INS_FRONT) ? '0 : r_cnt;
                            n_ra    = r_cnt;
                            n_state = full ? ST_DONE : ST_DESC;
                        end
                        OP_INS_SORTED: begin
                            n_state = full ? ST_DONE : ST_ASC;
                        end
                        OP_INS_AT: begin
                            n_slot = CNT_W'(i_cmd.pos);
                            n_ra   = r_cnt;
                            if (full || (PCMP_W'(i_cmd.pos) > PCMP_W'(r_cnt))) begin
                                n_state = ST_DONE;
                            end else begin
                                n_state = ST_DESC;
                            end
                        end
                        OP_SEARCH, OP_DEL_ITEM, OP_DEL_ALL: begin
                            n_state = ST_ASC;
                        end
                        OP_DEL_FRONT: begin
                            n_tgt   = '0;
                            n_state = ST_ASC;
                        end
                        OP_DEL_REAR: begin
                            // empty list wraps to all ones, which matches no slot
                            n_tgt   = PCMP_W'(r_cnt) - PCMP_W'(1);
                            n_state = ST_ASC;
                        end
                        OP_DEL_AT: begin
                            n_tgt   = PCMP_W'(i_cmd.pos);
                            n_state = ST_ASC;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end

            ST_ASC: begin
                // issue ascending reads
                if (r_ra < r_cnt) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_ra[ADDR_W-1:0];
                    n_ra      = r_ra + CNT_W'(1);
                    n_dv      = 1'b1;
                    n_di      = r_ra[ADDR_W-1:0];
                end else begin
                    n_dv = 1'b0;
                end

                // consume the entry read last cycle
                if (r_dv) begin
                    if (r_cmd.op == OP_INS_SORTED) begin
                        if (!r_hit && !($signed(rd) < $signed(r_cmd.word))) begin
                            n_hit  = 1'b1;
                            n_slot = CNT_W'(r_di);
                        end
                    end else if (r_cmd.op == OP_SEARCH) begin
                        if (key_match) begin
                            n_hit = 1'b1;
                        end
                    end else if (drop) begin
                        n_hit = 1'b1;
                    end else begin
                        // compaction: keep the entry at the write pointer
                        ram_we    = 1'b1;
                        ram_waddr = r_j[ADDR_W-1:0];
                        ram_wdata = rd;
                        n_j       = r_j + CNT_W'(1);
                    end
                end

                // pass finished
                if (!r_dv && (r_ra >= r_cnt)) begin
                    if (r_cmd.op == OP_INS_SORTED) begin
                        n_slot  = r_hit ? r_slot : r_cnt;
                        n_ra    = r_cnt;
                        n_dv    = 1'b0;
                        n_state = ST_DESC;
                    end else if (r_cmd.op == OP_SEARCH) begin
                        n_res.ok    = 1'b1;
                        n_res.found = r_hit;
                        n_res.value = r_hit ? key_sext : '1;
                        n_state     = ST_DONE;
                    end else begin
                        n_cnt         = r_j;
                        n_res.ok      = (removed != '0);
                        n_res.found   = (removed != '0) && !is_pos_del;
                        n_res.value   = ((r_cmd.op == OP_DEL_ALL) && (removed != '0))
                                      ? key_sext : '1;
                        n_res.removed = NUM_W'(removed);
                        n_res.count   = NUM_W'(r_j);
                        n_state       = ST_DONE;
                    end
                end
            end

            ST_DESC: begin
                // issue descending reads down to the slot
                if (r_ra > r_slot) begin
                    ram_re    = 1'b1;
                    ram_raddr = ADDR_W'(r_ra - CNT_W'(1));
                    n_ra      = r_ra - CNT_W'(1);
                    n_dv      = 1'b1;
                    n_di      = ADDR_W'(r_ra - CNT_W'(1));
                end else begin
                    n_dv = 1'b0;
                end

                // move each entry up one slot
                if (r_dv) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_di + ADDR_W'(1);
                    ram_wdata = rd;
                end

                // gap open: drop the new word in
                if (!r_dv && (r_ra <= r_slot)) begin
                    ram_we      = 1'b1;
                    ram_waddr   = r_slot[ADDR_W-1:0];
                    ram_wdata   = r_cmd.word;
                    n_cnt       = r_cnt + CNT_W'(1);
                    n_res.ok    = 1'b1;
                    n_res.count = NUM_W'(r_cnt + CNT_W'(1));
                    n_state     = ST_DONE;
                end
            end

            ST_DONE: begin
                if (i_take) begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_dv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_dv    <= n_dv;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_ra   <= n_ra;
        r_di   <= n_di;
        r_j    <= n_j;
        r_hit  <= n_hit;
        r_slot <= n_slot;
        r_tgt  <= n_tgt;
        r_res  <= n_res;
    end

    assign o_idle = (r_state == ST_IDLE);
    assign o_done = (r_state == ST_DONE);
    assign o_res  = r_res;

    // Checks
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_ram_hazard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("read and write hit the same entry");

    a_compact_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ASC && r_dv) |-> (r_j <= CNT_W'(r_di)))
        else $error("compaction write pointer overtook read");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && !i_take) |=> (r_state == ST_DONE && $stable(r_res)))
        else $error("pending result changed before handoff");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == ST_IDLE))
        else $error("command started while busy");

endmodule

>>> rtl/bounded_ordered_list_engine.sv
// Throughput: one command at a time; one list entry moves per cycle through the
//   single read and single write port of the entry RAM.
// Reset: synchronous, active low; clears the entry count and handshake state.
//   Entry storage is not cleared; slots at or above the count are never read.
module bounded_ordered_list_engine (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [bole_pkg::OP_W-1:0]   i_opcode,
    input  logic signed [bole_pkg::VAL_W-1:0] i_value,
    input  logic [bole_pkg::POS_W-1:0]  i_position,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_ok,
    output logic                        o_found,
    output logic signed [bole_pkg::VAL_W-1:0] o_result_value,
    output logic [bole_pkg::NUM_W-1:0]  o_removed_count,
    output logic [bole_pkg::NUM_W-1:0]  o_entry_count
);
    import bole_pkg::*;

    t_cmd    cmd;
    t_result eng_res;
    t_result r_out;
    logic    eng_idle, eng_done, start, take;
    logic    r_out_valid, n_out_valid;

    // Input beat accepted only while the engine is idle
    assign o_in_stall = !eng_idle;
    assign start      = i_in_valid && !o_in_stall;
    assign cmd.op     = i_opcode;
    assign cmd.word   = DATA_WIDTH'($unsigned(i_value));
    assign cmd.pos    = i_position;

    bole_eng u_eng (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_cmd  (cmd),
        .i_take (take),
        .o_idle (eng_idle),
        .o_done (eng_done),
        .o_res  (eng_res)
    );

    // Output register: frees the engine while a result waits downstream
    assign take        = eng_done && (!r_out_valid || !i_out_stall);
    assign n_out_valid = take || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= eng_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_ok            = r_out.ok;
    assign o_found         = r_out.found;
    assign o_result_value  = $signed(r_out.value);
    assign o_removed_count = r_out.removed;
    assign o_entry_count   = r_out.count;

endmodule
